// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: label");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and codes for the sorted minimum priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned CountWidth  = 5;
   localparam int unsigned CmdWidth    = 2;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned RspWidth    = 48;

   localparam logic [CmdWidth-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CmdWidth-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CmdWidth-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [StatusWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef logic signed [ValueWidth-1:0] value_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE
   } cell_op_type;

   // broadcast to every cell in the row
   typedef struct packed {
      cell_op_type op;
      value_type   value;
   } cell_ctrl_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [CountWidth-1:0]  count;
      logic [StatusWidth-1:0] status;
      value_type              value;
   } result_type;

endpackage

// ===== rtl/smpq_cell.sv =====
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted row: compare against the broadcast word and shift.
// ----------------------------------------------------------------------------
module smpq_cell (
   input  logic                    clock,
   input  smpq_pkg::cell_ctrl_type ctrl,
   input  logic                    in_use,
   input  smpq_pkg::value_type     left_value,
   input  logic                    left_greater,
   input  smpq_pkg::value_type     right_value,
   output smpq_pkg::value_type     value,
   output logic                    greater
);

   smpq_pkg::value_type value_ff;
   smpq_pkg::value_type value_in;

   // unused slots act as +infinity
   assign greater = !in_use || (value_ff > ctrl.value);
   assign value   = value_ff;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         smpq_pkg::OP_INSERT: begin
            if (greater) begin
               value_in = left_greater ? left_value : ctrl.value;
            end
         end
         smpq_pkg::OP_REMOVE: value_in = right_value;
         smpq_pkg::OP_HOLD:   value_in = value_ff;
         default:             value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== rtl/sorted_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Sorted-row priority queue: enqueue, dequeue of the minimum, clear.
//
//   channel  dir  tdata                                      tuser
//   req_     in   [31:0] value_in                            [1:0] command
//   rsp_     out  [31:0] value_out [33:32] status [38:34]    -
//                 count [39] empty_res [40] full_res
//
// One word per cycle while req_tready is high: every slot compares and shifts
// in parallel against the broadcast word, so each command finishes in the
// cycle it is taken. The result is registered in a two-entry output stage
// that keeps taking words while one result waits. Reset empties the queue.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // value_in
   input  logic [smpq_pkg::CmdWidth-1:0]       req_tuser,  // command
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // value_out, status, count, empty_res, full_res, zero pad
   output logic [smpq_pkg::RspWidth-1:0]       rsp_tdata
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]          count_ff, count_in;
   logic                   accept;
   logic                   is_full, is_empty;
   smpq_pkg::cell_ctrl_type ctrl;
   smpq_pkg::result_type   result;
   smpq_pkg::result_type   out_ff, out_in, skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                   out_free;

   smpq_pkg::value_type    cell_value [CAPACITY];
   logic                   cell_greater [CAPACITY];

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   // command decode and count update
   always_comb begin
      ctrl.op       = smpq_pkg::OP_HOLD;
      ctrl.value    = $signed(req_tdata);
      count_in      = count_ff;
      result.value  = '0;
      result.status = smpq_pkg::STATUS_OK;
      if (accept) begin
         priority if (req_tuser == smpq_pkg::CMD_ENQUEUE) begin
            if (is_full) begin
               result.status = smpq_pkg::STATUS_OVERFLOW;
            end else begin
               ctrl.op  = smpq_pkg::OP_INSERT;
               count_in = count_ff + CW'(1);
            end
         end else if (req_tuser == smpq_pkg::CMD_DEQUEUE) begin
            if (is_empty) begin
               result.status = smpq_pkg::STATUS_UNDERFLOW;
            end else begin
               ctrl.op      = smpq_pkg::OP_REMOVE;
               count_in     = count_ff - CW'(1);
               result.value = cell_value[0];
            end
         end else if (req_tuser == smpq_pkg::CMD_CLEAR) begin
            count_in = '0;
         end else begin
            // unused code: no operation
            count_in = count_ff;
         end
      end
      result.count = smpq_pkg::CountWidth'(count_in);
      result.empty = (count_in == '0);
      result.full  = (count_in == CW'(CAPACITY));
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      smpq_pkg::value_type left_v, right_v;
      logic                left_g;
      if (i == 0) begin : g_first
         assign left_v = cell_value[i];
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_g = cell_greater[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = cell_value[i];
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end
      smpq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .in_use       (CW'(i) < count_ff),
         .left_value   (left_v),
         .left_greater (left_g),
         .right_value  (right_v),
         .value        (cell_value[i]),
         .greater      (cell_greater[i])
      );
   end

   // output register plus skid entry
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = smpq_pkg::RspWidth'(out_ff);

endmodule

// ===== rtl/smpq_checker.sv =====
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smpq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [smpq_pkg::RspWidth-1:0] rsp_tdata
);

   logic                                over, under, empty, full;
   logic [31:0]                         value;

   assign value = rsp_tdata[31:0];
   assign over  = (rsp_tdata[33:32] == smpq_pkg::STATUS_OVERFLOW);
   assign under = (rsp_tdata[33:32] == smpq_pkg::STATUS_UNDERFLOW);
   assign empty = rsp_tdata[39];
   assign full  = rsp_tdata[40];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(a_not_both, clock, reset, rsp_tvalid, !(empty && full))
   `ASSERT_IMPLIES(a_overflow, clock, reset, rsp_tvalid && over, full && value == '0)
   `ASSERT_IMPLIES(a_underflow, clock, reset, rsp_tvalid && under, empty && value == '0)

endmodule

bind sorted_min_priority_queue smpq_checker u_smpq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
